// ===== hdl/lane_center_pd_steering_defines.svh =====
// Assertion macros shared by the lane-center steering checker.
`ifndef LANE_CENTER_PD_STEERING_DEFINES_SVH
`define LANE_CENTER_PD_STEERING_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCPS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LCPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication after a fixed number of cycles, disabled while reset is asserted.
`define LCPS_ASSERT_AFTER(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ===== hdl/lcps_pkg.sv =====
// Shared constants and field widths for the lane-center PD steering block.
package lcps_pkg;

  // Field widths.
  localparam int PIX_W   = 8;
  localparam int COL_W   = 11;
  localparam int ROW_W   = 11;
  localparam int IW_W    = 12;
  localparam int GAIN_W  = 16;
  localparam int YAW_W   = 8;
  localparam int STEER_W = 8;
  localparam int LOFF_W  = 12;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_TOP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BOTTOM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_OFFSET  = 3'd5;

  // Register reset values.
  localparam logic [ROW_W-1:0]  ROW_TOP_RST     = 11'd280;
  localparam logic [ROW_W-1:0]  ROW_BOTTOM_RST  = 11'd350;
  localparam logic [IW_W-1:0]   IMAGE_WIDTH_RST = 12'd640;
  localparam logic [GAIN_W-1:0] GAIN_P_RST      = 16'd128;
  localparam logic [GAIN_W-1:0] GAIN_D_RST      = 16'd5120;
  localparam logic [YAW_W-1:0]  YAW_OFFSET_RST  = 8'hF8;

  // Largest supported row width.
  localparam int MAX_WIDTH_DEF = 2048;

  // Steering range.
  localparam int STEER_CENTER = 90;
  localparam int STEER_MAX    = 180;

  // Exact floor(x / 25) for x below 2^21: (x * DIV25_MUL) >> DIV25_SHIFT.
  localparam int DIV25_MUL_W = 22;
  localparam logic [DIV25_MUL_W-1:0] DIV25_MUL = 22'd2684355;
  localparam int DIV25_SHIFT = 26;

endpackage

// ===== hdl/lane_center_pd_steering.sv =====
// Lane-center PD steering: edge-pixel row tracking and steering command pipeline.
//
// The input channel carries one edge-map pixel per transfer in raster order, with its
// column, its row and an end_of_frame flag on the last pixel of the frame. Pixels on
// the two configured rows update the leftmost and rightmost edge columns of each row
// in the same cycle, so the block takes one pixel every clock while in_ready is high.
// The pixel that carries end_of_frame is tracked like any other and then closes the
// frame: the four columns are snapshot, the trackers reload, and the frame result
// (steering command and lane offset) runs through four register stages and then the
// output register onto the output channel.
// Pixels that do not end a frame produce no result.
// When the receiver stalls, the output register holds its result and the stages
// behind it keep filling; in_ready only drops when every stage holds a frame result.
// The configuration port writes one register per cycle. The user must write only
// while the block is idle; the block itself does not enforce it.
// Synchronous reset loads the register defaults, clears the row trackers, the
// previous-frame offset and all stage valid bits.
module lane_center_pd_steering
  import lcps_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Pixel input channel.
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel,
  input  logic [COL_W-1:0]      in_column,
  input  logic [ROW_W-1:0]      in_row,
  input  logic                  in_end_of_frame,
  // Steering result channel.
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STEER_W-1:0]    out_steer,
  output logic signed [LOFF_W-1:0] out_lane_offset
);

  // Width of an effective row width (1..MAX_WIDTH) and of the extended input column.
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CW    = (WW > COL_W) ? WW : COL_W;
  // Lane offset, offset change, and the product widths derived from them.
  localparam int OFF_W = WW + 1;
  localparam int DM_W  = OFF_W + 1;
  localparam int PQ_W  = OFF_W + GAIN_W - 8;
  localparam int DX_W  = DM_W + GAIN_W - 10;
  localparam int DQ_W  = DX_W + DIV25_MUL_W - DIV25_SHIFT;
  localparam int ST_W  = PQ_W + 3;

  // Configuration registers.
  logic [ROW_W-1:0]        row_top_r, row_bottom_r;
  logic [IW_W-1:0]         image_width_r;
  logic [GAIN_W-1:0]       gain_p_r, gain_d_r;
  logic signed [YAW_W-1:0] yaw_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_top_r     <= ROW_TOP_RST;
      row_bottom_r  <= ROW_BOTTOM_RST;
      image_width_r <= IMAGE_WIDTH_RST;
      gain_p_r      <= GAIN_P_RST;
      gain_d_r      <= GAIN_D_RST;
      yaw_offset_r  <= YAW_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_TOP:     row_top_r     <= cfg_wdata[ROW_W-1:0];
        REG_ROW_BOTTOM:  row_bottom_r  <= cfg_wdata[ROW_W-1:0];
        REG_IMAGE_WIDTH: image_width_r <= cfg_wdata[IW_W-1:0];
        REG_GAIN_P:      gain_p_r      <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:      gain_d_r      <= cfg_wdata[GAIN_W-1:0];
        REG_YAW_OFFSET:  yaw_offset_r  <= cfg_wdata[YAW_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and stage flow control. Each stage takes a new entry when it is empty
  // or when its own entry moves on in the same cycle.
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_valid_r;
  logic out_rdy, s4_rdy, s3_rdy, s2_rdy, s1_rdy;
  logic in_fire, eof_fire;

  assign out_rdy  = !out_valid_r || out_ready;
  assign s4_rdy   = !s4_v_r || out_rdy;
  assign s3_rdy   = !s3_v_r || s4_rdy;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;
  assign in_fire  = in_valid && in_ready;
  assign eof_fire = in_fire && in_end_of_frame;

  // Effective width: image_width clamped to 1..MAX_WIDTH.
  logic [WW-1:0] w_eff;
  always_comb begin
    if (image_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(image_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width_r);
    end
  end

  // Row trackers. A row's left/right columns are only meaningful once it has seen
  // an edge; until then the frame result uses the width and zero defaults.
  logic          top_seen_r, bot_seen_r;
  logic [WW-1:0] top_left_r, top_right_r, bot_left_r, bot_right_r;
  logic          top_seen_nxt, bot_seen_nxt;
  logic [WW-1:0] top_left_nxt, top_right_nxt, bot_left_nxt, bot_right_nxt;
  logic [CW-1:0] col_ext;
  logic [WW-1:0] col_w;
  logic          hit, hit_top, hit_bot;
  logic [WW-1:0] snap_tl, snap_tr, snap_bl, snap_br;

  always_comb begin
    col_ext = CW'(in_column);
    // Only used on a hit, where the column is below the width and so fits WW bits.
    col_w   = col_ext[WW-1:0];
    hit     = (in_pixel != '0) && (col_ext < CW'(w_eff));
    hit_top = hit && (in_row == row_top_r);
    hit_bot = hit && (in_row == row_bottom_r);

    top_seen_nxt  = top_seen_r;
    top_left_nxt  = top_left_r;
    top_right_nxt = top_right_r;
    if (hit_top) begin
      top_seen_nxt = 1'b1;
      if (!top_seen_r) begin
        top_left_nxt  = col_w;
        top_right_nxt = col_w;
      end else begin
        if (col_w < top_left_r) top_left_nxt = col_w;
        if (col_w > top_right_r) top_right_nxt = col_w;
      end
    end

    bot_seen_nxt  = bot_seen_r;
    bot_left_nxt  = bot_left_r;
    bot_right_nxt = bot_right_r;
    if (hit_bot) begin
      bot_seen_nxt = 1'b1;
      if (!bot_seen_r) begin
        bot_left_nxt  = col_w;
        bot_right_nxt = col_w;
      end else begin
        if (col_w < bot_left_r) bot_left_nxt = col_w;
        if (col_w > bot_right_r) bot_right_nxt = col_w;
      end
    end

    // Frame-end snapshot, with the end_of_frame pixel already taken into account.
    snap_tl = top_seen_nxt ? top_left_nxt  : w_eff;
    snap_tr = top_seen_nxt ? top_right_nxt : '0;
    snap_bl = bot_seen_nxt ? bot_left_nxt  : w_eff;
    snap_br = bot_seen_nxt ? bot_right_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_seen_r <= 1'b0;
      bot_seen_r <= 1'b0;
    end else if (in_fire) begin
      top_seen_r <= top_seen_nxt && !in_end_of_frame;
      bot_seen_r <= bot_seen_nxt && !in_end_of_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      top_left_r  <= top_left_nxt;
      top_right_r <= top_right_nxt;
      bot_left_r  <= bot_left_nxt;
      bot_right_r <= bot_right_nxt;
    end
  end

  // Stage 1: frame snapshot.
  logic [WW-1:0] s1_tl_r, s1_tr_r, s1_bl_r, s1_br_r, s1_w_r;

  always_ff @(posedge clk) begin
    if (s1_rdy && eof_fire) begin
      s1_tl_r <= snap_tl;
      s1_tr_r <= snap_tr;
      s1_bl_r <= snap_bl;
      s1_br_r <= snap_br;
      s1_w_r  <= w_eff;
    end
  end

  // Lane middle, offset from center and change against the previous frame. Results
  // leave stage 1 in order, so the previous frame's offset is already stored here.
  logic [WW+1:0]          col_sum;
  logic [WW-1:0]          middle;
  logic signed [OFF_W-1:0] off_c, last_offset_r;
  logic signed [DM_W-1:0]  delta_c;
  logic                   p_neg_c, d_neg_c;
  logic [OFF_W-1:0]       p_abs_c;
  logic [DM_W-1:0]        d_abs_c;

  always_comb begin
    col_sum = (WW+2)'(s1_tl_r) + (WW+2)'(s1_tr_r) + (WW+2)'(s1_bl_r) + (WW+2)'(s1_br_r);
    middle  = col_sum[WW+1:2];
    off_c   = OFF_W'({1'b0, s1_w_r >> 1}) - OFF_W'({1'b0, middle});
    delta_c = DM_W'(off_c) - DM_W'(last_offset_r);
    // Both terms enter the steering sum negated, so a positive offset gives a
    // negative proportional term.
    p_neg_c = off_c > 0;
    d_neg_c = delta_c > 0;
    p_abs_c = off_c[OFF_W-1] ? OFF_W'(-off_c) : OFF_W'(off_c);
    d_abs_c = delta_c[DM_W-1] ? DM_W'(-delta_c) : DM_W'(delta_c);
  end

  // Stage 2: signed offset and term magnitudes.
  logic signed [OFF_W-1:0] s2_off_r;
  logic                    s2_pneg_r, s2_dneg_r;
  logic [OFF_W-1:0]        s2_pabs_r;
  logic [DM_W-1:0]         s2_dabs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_offset_r <= '0;
    end else if (s2_rdy && s1_v_r) begin
      last_offset_r <= off_c;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) begin
      s2_off_r  <= off_c;
      s2_pneg_r <= p_neg_c;
      s2_dneg_r <= d_neg_c;
      s2_pabs_r <= p_abs_c;
      s2_dabs_r <= d_abs_c;
    end
  end

  // Gain products. Truncation toward zero works on magnitudes: the proportional
  // term drops 8 fraction bits, the derivative term drops 10 bits here and is
  // divided by 25 in the next stage (25600 = 1024 * 25).
  logic [OFF_W+GAIN_W-1:0] p_prod;
  logic [DM_W+GAIN_W-1:0]  d_prod;

  assign p_prod = (OFF_W+GAIN_W)'(s2_pabs_r) * (OFF_W+GAIN_W)'(gain_p_r);
  assign d_prod = (DM_W+GAIN_W)'(s2_dabs_r) * (DM_W+GAIN_W)'(gain_d_r);

  // Stage 3: proportional magnitude and pre-scaled derivative magnitude.
  logic signed [OFF_W-1:0] s3_off_r;
  logic                    s3_pneg_r, s3_dneg_r;
  logic [PQ_W-1:0]         s3_pq_r;
  logic [DX_W-1:0]         s3_dx_r;

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_v_r) begin
      s3_off_r  <= s2_off_r;
      s3_pneg_r <= s2_pneg_r;
      s3_dneg_r <= s2_dneg_r;
      s3_pq_r   <= p_prod[OFF_W+GAIN_W-1:8];
      s3_dx_r   <= d_prod[DM_W+GAIN_W-1:10];
    end
  end

  // Divide by 25 with an exact reciprocal for dividends below 2^21.
  logic [DX_W+DIV25_MUL_W-1:0] div_prod;

  assign div_prod = (DX_W+DIV25_MUL_W)'(s3_dx_r) * (DX_W+DIV25_MUL_W)'(DIV25_MUL);

  // Stage 4: both term magnitudes ready.
  logic signed [OFF_W-1:0] s4_off_r;
  logic                    s4_pneg_r, s4_dneg_r;
  logic [PQ_W-1:0]         s4_pq_r;
  logic [DQ_W-1:0]         s4_dq_r;

  always_ff @(posedge clk) begin
    if (s4_rdy && s3_v_r) begin
      s4_off_r  <= s3_off_r;
      s4_pneg_r <= s3_pneg_r;
      s4_dneg_r <= s3_dneg_r;
      s4_pq_r   <= s3_pq_r;
      s4_dq_r   <= div_prod[DX_W+DIV25_MUL_W-1:DIV25_SHIFT];
    end
  end

  // Steering sum: center plus trim minus both terms, then saturation to 0..180.
  logic signed [ST_W-1:0] base_s, p_s, d_s, sum_s;
  logic signed [ST_W-1:0] steer_max_s;
  logic [STEER_W-1:0]     steer_c;

  always_comb begin
    steer_max_s = ST_W'(STEER_MAX);
    base_s      = ST_W'(yaw_offset_r) + ST_W'(STEER_CENTER);
    p_s         = s4_pneg_r ? ST_W'(s4_pq_r) : -ST_W'(s4_pq_r);
    d_s         = s4_dneg_r ? ST_W'(s4_dq_r) : -ST_W'(s4_dq_r);
    sum_s       = base_s + p_s + d_s;
    if (sum_s < 0) begin
      steer_c = '0;
    end else if (sum_s > steer_max_s) begin
      steer_c = STEER_W'(STEER_MAX);
    end else begin
      steer_c = sum_s[STEER_W-1:0];
    end
  end

  // Output register.
  logic [STEER_W-1:0]       out_steer_r;
  logic signed [LOFF_W-1:0] out_lane_offset_r;

  always_ff @(posedge clk) begin
    if (out_rdy && s4_v_r) begin
      out_steer_r       <= steer_c;
      out_lane_offset_r <= LOFF_W'(s4_off_r);
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= eof_fire;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
      if (s4_rdy) s4_v_r <= s3_v_r;
      if (out_rdy) out_valid_r <= s4_v_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_steer       = out_steer_r;
  assign out_lane_offset = out_lane_offset_r;

endmodule

// ===== hdl/lcps_checker.sv =====
// Port-level checker for the lane-center PD steering block, with its bind.
`include "lane_center_pd_steering_defines.svh"

module lcps_port_checker
  import lcps_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_end_of_frame,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [STEER_W-1:0]       out_steer,
  input logic signed [LOFF_W-1:0] out_lane_offset
);

  // The steering command never leaves its saturated range.
  `LCPS_ASSERT_IMPLIES(a_steer_range, out_valid, out_steer <= STEER_W'(STEER_MAX), "steer above range")

  // With the output register empty, every stage can move, so pixels are taken.
  `LCPS_ASSERT_IMPLIES(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

  // The result of a frame end passes stages 1 to 4 into the output register unless a
  // result waits there, so out_valid is seen once it has passed, either for it or for a waiting result.
  `LCPS_ASSERT_AFTER(a_eof_latency, in_valid && in_ready && in_end_of_frame, 5, out_valid, "frame result missing")

  // A stalled result holds until its transfer.
  `LCPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_steer) && $stable(out_lane_offset), "stalled result changed")

endmodule

bind lane_center_pd_steering lcps_port_checker u_lcps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_end_of_frame (in_end_of_frame),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_steer       (out_steer),
  .out_lane_offset (out_lane_offset)
);

// ===== dv/lcps_checker.sv =====
// Checker for the lane-center steering block: predicts each frame result and compares it.
`timescale 1ns / 100ps

module lcps_checker
  import lcps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [PIX_W-1:0]         in_pixel,
  input  logic [COL_W-1:0]         in_column,
  input  logic [ROW_W-1:0]         in_row,
  input  logic                     in_end_of_frame,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [STEER_W-1:0]       out_steer,
  input  logic signed [LOFF_W-1:0] out_lane_offset,
  output int                       fail_count,
  output int                       pending
);

  // Q8.8 unity, and the derivative scale (Q8.8 unity times the divide by 100).
  localparam longint GAIN_ONE = 256;
  localparam longint D_SCALE  = 25600;

  typedef struct packed {
    logic [STEER_W-1:0]       steer;
    logic signed [LOFF_W-1:0] lane_offset;
  } steer_result_t;

  steer_result_t steer_q[$];

  // Shadow copy of the configuration registers.
  logic [ROW_W-1:0]         row_top_r;
  logic [ROW_W-1:0]         row_bottom_r;
  logic [IW_W-1:0]          width_r;
  logic [GAIN_W-1:0]        gain_p_r;
  logic [GAIN_W-1:0]        gain_d_r;
  logic signed [YAW_W-1:0]  yaw_r;

  // Row trackers: index 0 is the top row, index 1 the bottom row.
  bit     edge_seen [2];
  int     edge_lo   [2];
  int     edge_hi   [2];
  longint prev_offset;

  task automatic predict_pixel(input logic [PIX_W-1:0] pix, input logic [COL_W-1:0] col,
                               input logic [ROW_W-1:0] row, input logic eof);
    int               w;
    int               r;
    longint           col_sum;
    longint           offs;
    longint           p_term;
    longint           d_term;
    longint           cmd;
    logic [ROW_W-1:0] scan_row [2];
    steer_result_t    res;
    w = (width_r == 0) ? 1 : ((width_r > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_r));
    scan_row[0] = row_top_r;
    scan_row[1] = row_bottom_r;
    if (pix != 0 && col < w) begin
      for (r = 0; r < 2; r++) begin
        if (row == scan_row[r]) begin
          if (!edge_seen[r]) begin
            edge_seen[r] = 1'b1;
            edge_lo[r] = int'(col);
            edge_hi[r] = int'(col);
          end else begin
            if (col < edge_lo[r]) edge_lo[r] = int'(col);
            if (col > edge_hi[r]) edge_hi[r] = int'(col);
          end
        end
      end
    end
    if (eof) begin
      // A row without edges contributes the width on the left and zero on the right.
      col_sum = 0;
      for (r = 0; r < 2; r++) begin
        col_sum += edge_seen[r] ? longint'(edge_lo[r]) + longint'(edge_hi[r]) : longint'(w);
      end
      offs = longint'(w / 2) - col_sum / 4;
      p_term = (-offs * longint'(gain_p_r)) / GAIN_ONE;
      d_term = (-(offs - prev_offset) * longint'(gain_d_r)) / D_SCALE;
      cmd = longint'(STEER_CENTER) + longint'(yaw_r) - (p_term + d_term);
      if (cmd < 0) cmd = 0;
      if (cmd > STEER_MAX) cmd = longint'(STEER_MAX);
      res.steer = STEER_W'(cmd);
      res.lane_offset = LOFF_W'(offs);
      steer_q.push_back(res);
      prev_offset = offs;
      edge_seen[0] = 1'b0;
      edge_seen[1] = 1'b0;
    end
  endtask

  always @(posedge clk) begin : monitor
    steer_result_t exp_res;
    if (!rst_n) begin
      row_top_r    = ROW_TOP_RST;
      row_bottom_r = ROW_BOTTOM_RST;
      width_r      = IMAGE_WIDTH_RST;
      gain_p_r     = GAIN_P_RST;
      gain_d_r     = GAIN_D_RST;
      yaw_r        = YAW_OFFSET_RST;
      edge_seen[0] = 1'b0;
      edge_seen[1] = 1'b0;
      prev_offset  = 0;
      fail_count   = 0;
      steer_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW_TOP:     row_top_r    = cfg_wdata[ROW_W-1:0];
          REG_ROW_BOTTOM:  row_bottom_r = cfg_wdata[ROW_W-1:0];
          REG_IMAGE_WIDTH: width_r      = cfg_wdata[IW_W-1:0];
          REG_GAIN_P:      gain_p_r     = cfg_wdata[GAIN_W-1:0];
          REG_GAIN_D:      gain_d_r     = cfg_wdata[GAIN_W-1:0];
          REG_YAW_OFFSET:  yaw_r        = cfg_wdata[YAW_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (steer_q.size() == 0) begin
          $error("unexpected result: steer %0d lane_offset %0d", out_steer, out_lane_offset);
          fail_count++;
        end else begin
          exp_res = steer_q.pop_front();
          if (out_steer !== exp_res.steer) begin
            $error("steer: expected %0d, actual %0d", exp_res.steer, out_steer);
            fail_count++;
          end
          if (out_lane_offset !== exp_res.lane_offset) begin
            $error("lane_offset: expected %0d, actual %0d", exp_res.lane_offset,
                   out_lane_offset);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_pixel(in_pixel, in_column, in_row, in_end_of_frame);
      end
    end
    pending = steer_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Top of the lane-center steering testbench: clock, reset, stimulus, sink and verdict.
`timescale 1ns / 100ps

module tb_top;
  import lcps_pkg::*;

  // Indexes that no register answers to; writes there must leave the block unchanged.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Cycles the sink refuses results during the back-pressure phase.
  localparam int HOLD_CYCLES = 100;
  // Random items per configuration phase.
  localparam int PHASE_ITEMS = 32;
  localparam int PHASE_COUNT = 11;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic [PIX_W-1:0]         in_pixel;
  logic [COL_W-1:0]         in_column;
  logic [ROW_W-1:0]         in_row;
  logic                     in_end_of_frame;
  logic                     out_valid;
  logic                     out_ready;
  logic [STEER_W-1:0]       out_steer;
  logic signed [LOFF_W-1:0] out_lane_offset;

  int fail_count;
  int pending;

  // Stimulus-side view of the configuration, used to aim pixels at the scanned rows.
  logic [ROW_W-1:0] cur_row_top;
  logic [ROW_W-1:0] cur_row_bottom;
  int               eff_w;

  // steady turns off all idling on both sides; hold_req asks the sink for a long hold-off.
  bit steady;
  bit hold_req;

  lane_center_pd_steering u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel        (in_pixel),
    .in_column       (in_column),
    .in_row          (in_row),
    .in_end_of_frame (in_end_of_frame),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_steer       (out_steer),
    .out_lane_offset (out_lane_offset)
  );

  lcps_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel        (in_pixel),
    .in_column       (in_column),
    .in_row          (in_row),
    .in_end_of_frame (in_end_of_frame),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_steer       (out_steer),
    .out_lane_offset (out_lane_offset),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Idle length used by both sides: mostly none or short, now and then a long one.
  function automatic int pause_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (steady || sel < 65) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    if (sel < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Columns mostly fall inside the row, with the two ends and out-of-row values mixed in.
  function automatic logic [COL_W-1:0] pick_column();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return COL_W'($urandom_range(0, eff_w - 1));
    if (sel == 6) return '0;
    if (sel == 7) return COL_W'(eff_w - 1);
    return COL_W'($urandom);
  endfunction

  // Rows are mostly the two scanned ones so the trackers see plenty of edges.
  function automatic logic [ROW_W-1:0] pick_row();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return cur_row_top;
    if (sel < 8) return cur_row_bottom;
    return ROW_W'($urandom);
  endfunction

  // Result sink. It owns out_ready and changes it on falling edges only. A hold-off
  // request is served once per request and counted here, independent of the sender.
  initial begin : result_sink
    int  ready_run;
    int  stall_run;
    int  quiet;
    bit  held;
    ready_run = 0;
    stall_run = 0;
    quiet = 0;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_req) begin
        held = 1'b0;
      end else if (!held) begin
        held = 1'b1;
        quiet = HOLD_CYCLES;
      end
      if (quiet > 0) begin
        quiet--;
        out_ready <= 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else if (ready_run > 0) begin
        ready_run--;
        out_ready <= 1'b1;
      end else if (stall_run > 0) begin
        stall_run--;
        out_ready <= 1'b0;
      end else begin
        ready_run = $urandom_range(0, 15);
        stall_run = pause_len();
        out_ready <= 1'b1;
      end
    end
  end

  // One transfer on the pixel channel. Inputs change on falling edges; valid is lowered
  // only for an idle gap, so back-to-back pixels keep it high with a single assignment.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic [COL_W-1:0] col,
                            input logic [ROW_W-1:0] row, input logic eof);
    int gap;
    gap = pause_len();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_pixel        <= pix;
    in_column       <= col;
    in_row          <= row;
    in_end_of_frame <= eof;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drain the block: stop the input and wait until no frame result is left to arrive,
  // so that configuration writes always land on an idle block.
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Writes all six registers. Bits above the width of the row, width and yaw registers
  // carry junk, which the block has to drop.
  task automatic apply_cfg(input logic [ROW_W-1:0] rt, input logic [ROW_W-1:0] rb,
                           input logic [IW_W-1:0] iw, input logic [GAIN_W-1:0] gp,
                           input logic [GAIN_W-1:0] gd, input logic [YAW_W-1:0] yaw);
    write_reg(REG_ROW_TOP,     {5'($urandom), rt});
    write_reg(REG_ROW_BOTTOM,  {5'($urandom), rb});
    write_reg(REG_IMAGE_WIDTH, {4'($urandom), iw});
    write_reg(REG_GAIN_P,      gp);
    write_reg(REG_GAIN_D,      gd);
    write_reg(REG_YAW_OFFSET,  {8'($urandom), yaw});
    cur_row_top    = rt;
    cur_row_bottom = rb;
    eff_w = (iw == 0) ? 1 : ((iw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(iw));
  endtask

  initial begin : stimulus
    int          sent;
    int          len;
    int          i;
    logic [IW_W-1:0] rand_w;
    logic [ROW_W-1:0] rand_rt;
    logic [ROW_W-1:0] rand_rb;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_pixel        = '0;
    in_column       = '0;
    in_row          = '0;
    in_end_of_frame = 1'b0;
    steady          = 1'b0;
    hold_req        = 1'b0;
    cur_row_top     = ROW_TOP_RST;
    cur_row_bottom  = ROW_BOTTOM_RST;
    eff_w           = IMAGE_WIDTH_RST;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Directed frames under the reset configuration (rows 280 and 350, width 640).
    // A frame of a single blank end-of-frame pixel: both rows fall back to defaults.
    send_pixel(8'd0, 11'd0, 11'd0, 1'b1);
    // Edges at both ends of the row, pixel values at the extremes, a column just past
    // the width and the top column (both ignored), a zero pixel on a scanned row, an
    // edge on an unscanned row, and an end-of-frame pixel that is itself an edge.
    send_pixel(8'd255, 11'd0, 11'd280, 1'b0);
    send_pixel(8'd1, 11'd639, 11'd280, 1'b0);
    send_pixel(8'd128, 11'd100, 11'd350, 1'b0);
    send_pixel(8'd7, 11'd500, 11'd350, 1'b0);
    send_pixel(8'd255, 11'd640, 11'd280, 1'b0);
    send_pixel(8'd255, 11'd2047, 11'd350, 1'b0);
    send_pixel(8'd0, 11'd50, 11'd280, 1'b0);
    send_pixel(8'd255, 11'd300, 11'd0, 1'b0);
    send_pixel(8'd9, 11'd20, 11'd350, 1'b1);
    // Only the top row has edges; the bottom row keeps its defaults.
    send_pixel(8'd3, 11'd1, 11'd280, 1'b0);
    send_pixel(8'd3, 11'd2, 11'd280, 1'b0);
    send_pixel(8'd255, 11'd2047, 11'd2047, 1'b1);

    // Width changed in the middle of a frame: the edge already taken stays, later
    // pixels are judged against the new width, and the lane offset is taken against it too.
    send_pixel(8'd255, 11'd600, 11'd280, 1'b0);
    drain_block();
    write_reg(REG_IMAGE_WIDTH, 16'd320);
    eff_w = 320;
    send_pixel(8'd255, 11'd10, 11'd350, 1'b0);
    send_pixel(8'd255, 11'd400, 11'd350, 1'b0);
    send_pixel(8'd255, 11'd319, 11'd280, 1'b0);
    send_pixel(8'd0, 11'd0, 11'd0, 1'b1);

    // Writes to unused indexes must change nothing; the yaw write carries junk above
    // its eight bits.
    drain_block();
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'hFFFF);
    write_reg(REG_YAW_OFFSET, 16'hFF5A);
    send_pixel(8'd200, 11'd5, 11'd280, 1'b0);
    send_pixel(8'd200, 11'd300, 11'd350, 1'b1);

    // Random phases, each under its own configuration. The first few sit on the
    // extremes: largest gains with the widest row, equal rows with zero gains and a
    // width beyond range, a zero width and the yaw limits.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      drain_block();
      case (ph)
        0: apply_cfg(11'd0, 11'd2047, 12'd2048, 16'hFFFF, 16'hFFFF, 8'd90);
        1: apply_cfg(11'd5, 11'd5, 12'd4095, 16'd0, 16'd0, 8'hA6);
        2: apply_cfg(11'd2047, 11'd0, 12'd0, 16'd256, 16'd25600, 8'h7F);
        3: apply_cfg(11'd1, 11'd2, 12'd16, 16'd1000, 16'd40000, 8'h80);
        4: apply_cfg(11'd3, 11'd7, 12'd1, 16'hFFFF, 16'd0, 8'h00);
        default: begin
          // Mostly narrow rows so columns land both inside and past the width.
          rand_w  = ($urandom_range(0, 9) < 7) ? IW_W'($urandom_range(8, 64)) : IW_W'($urandom);
          rand_rt = ROW_W'($urandom);
          rand_rb = ($urandom_range(0, 3) == 0) ? rand_rt : ROW_W'($urandom);
          apply_cfg(rand_rt, rand_rb, rand_w, GAIN_W'($urandom), GAIN_W'($urandom),
                    YAW_W'($urandom));
        end
      endcase
      steady = (ph == 6);

      // Back-pressure: the sink holds off while single-pixel frames keep coming, so
      // the result stages fill and the block has to stop taking pixels.
      if (ph == 5) begin
        @(posedge clk);
        hold_req = 1'b1;
        repeat (40) send_pixel(PIX_W'($urandom), pick_column(), pick_row(), 1'b1);
        hold_req = 1'b0;
      end

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = $urandom_range(1, 10);
        if ($urandom_range(0, 99) < 15) begin
          // Noise: any field value, and an end-of-frame only now and then, so frames
          // may run on across what would have been their end.
          for (i = 0; i < len; i++) begin
            send_pixel(PIX_W'($urandom), COL_W'($urandom), pick_row(),
                       ($urandom_range(0, 7) == 0));
          end
        end else begin
          for (i = 0; i < len; i++) begin
            send_pixel(($urandom_range(0, 3) == 0) ? 8'd0 : PIX_W'($urandom_range(1, 255)),
                       pick_column(), pick_row(), (i == len - 1));
          end
        end
        sent += len;
      end
    end

    // Let every outstanding frame result arrive, then allow for any stray output.
    steady = 1'b0;
    drain_block();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/lcps_pkg.sv
hdl/lane_center_pd_steering.sv
hdl/lcps_checker.sv
dv/lcps_checker.sv
dv/tb_top.sv
